/* hw/rtl/ccstcd_pkg.sv */
package ccstcd_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_FORMAT = 2'd2,
    ST_DOY    = 2'd3
  } status_t;

  localparam int unsigned DOY_W = 9;

  // days in the year before the first day of month m (m counts from 0)
  function automatic logic [DOY_W-1:0] days_before(input logic [3:0] m, input logic leap);
    logic [DOY_W-1:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m >= 4'd2) && (m <= 4'd11)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

/* hw/rtl/ccs_time_code_decoder.sv */
// Byte-serial decoder for calendar segmented time codes. One byte is taken per
// transaction on the data channel, one byte per clock when the result side does not
// stall; end_of_buffer marks the last byte of a buffer. A code is a header, two year
// bytes, month and day (or a 16-bit day of year when header bit 3 is set), hour,
// minute, second and n subsecond bytes, n being the header's low three bits. The
// byte that completes a code, or that carries end_of_buffer before the code is
// complete, yields one result in the output register on the next clock; status 1
// flags a cut-off code, 2 a field out of range (or n of seven), 3 a day of year past
// the end of that year. Decoded fields are zero unless status is 0; code_length is
// always 8 + n. Bytes after a complete code are dropped until end_of_buffer. The data
// side stalls only while a result waits in the output register under result_stall.
// Leap year terms are worked out from the year while the day bytes arrive, so no
// division sits on the path to the result.
module ccs_time_code_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [15:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [19:0] microsecond,
  output logic [3:0]  code_length
);
  import ccstcd_pkg::*;

  localparam logic [15:0] MAX_DOY      = 16'd366;
  localparam logic [7:0]  MAX_MONTH    = 8'd12;
  localparam logic [7:0]  MAX_DAY      = 8'd31;
  localparam logic [7:0]  MAX_HOUR     = 8'd23;
  localparam logic [7:0]  MAX_MIN_SEC  = 8'd59;
  localparam logic [7:0]  MAX_SUBSEC   = 8'd99;
  localparam logic [2:0]  BAD_COUNT    = 3'd7;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;
  // floor(q / 25) = (q * RECIP_25) >> RECIP_SHIFT, exact for q < 2^14
  localparam logic [14:0] RECIP_25     = 15'd20972;
  localparam int unsigned RECIP_SHIFT  = 19;

  // control state
  logic [3:0] byte_index;
  logic       skipping_rest;

  // captured fields
  logic [7:0]  header_byte;
  logic [15:0] year_value;
  logic [7:0]  month_or_doy_high;
  logic [7:0]  day_or_doy_low;
  logic [7:0]  hour_value;
  logic [7:0]  minute_value;
  logic [7:0]  second_value;
  logic [7:0]  hundredths_byte;
  logic [7:0]  ten_thousandths_byte;
  logic        subsecond_bad;
  logic [9:0]  quot_100;
  logic [7:0]  quot_400;

  logic [7:0]  header_byte_next;
  logic [7:0]  month_or_doy_high_next;
  logic [7:0]  day_or_doy_low_next;
  logic [7:0]  hour_value_next;
  logic [7:0]  minute_value_next;
  logic [7:0]  second_value_next;
  logic [7:0]  hundredths_byte_next;
  logic [7:0]  ten_thousandths_byte_next;
  logic        subsecond_bad_next;

  logic        accept;
  logic [3:0]  total;
  logic        done;
  logic        emit;
  logic        cut_off;

  logic [28:0] prod_100;
  logic [26:0] prod_400;
  logic        div_4;
  logic        div_100;
  logic        div_400;
  logic        leap;

  logic        doy_form;
  logic [15:0] doy;
  logic        fmt_bad;
  logic        doy_bad;
  logic [3:0]  month_idx;
  logic [DOY_W-1:0] doy_day;
  status_t     status_next;

  assign data_stall = result_valid && result_stall;
  assign accept     = data_valid && !data_stall;

  always_comb begin
    header_byte_next          = header_byte;
    month_or_doy_high_next    = month_or_doy_high;
    day_or_doy_low_next       = day_or_doy_low;
    hour_value_next           = hour_value;
    minute_value_next         = minute_value;
    second_value_next         = second_value;
    hundredths_byte_next      = hundredths_byte;
    ten_thousandths_byte_next = ten_thousandths_byte;
    subsecond_bad_next        = subsecond_bad;
    case (byte_index)
      4'd0: begin
        header_byte_next          = data_byte;
        hundredths_byte_next      = 8'd0;
        ten_thousandths_byte_next = 8'd0;
        subsecond_bad_next        = 1'b0;
      end
      4'd1, 4'd2: ;
      4'd3: month_or_doy_high_next = data_byte;
      4'd4: day_or_doy_low_next    = data_byte;
      4'd5: hour_value_next        = data_byte;
      4'd6: minute_value_next      = data_byte;
      4'd7: second_value_next      = data_byte;
      default: begin
        if (byte_index == 4'd8) hundredths_byte_next = data_byte;
        if (byte_index == 4'd9) ten_thousandths_byte_next = data_byte;
        if (data_byte > MAX_SUBSEC) subsecond_bad_next = 1'b1;
      end
    endcase
  end

  assign total   = 4'd8 + {1'b0, header_byte_next[2:0]};
  assign done    = ({1'b0, byte_index} + 5'd1) >= {1'b0, total};
  assign emit    = accept && !skipping_rest && (done || end_of_buffer);
  assign cut_off = !done;

  // year quotients by 25, taken once the year is in, for the leap test
  assign prod_100 = {1'b0, year_value[15:2]} * {14'd0, RECIP_25};
  assign prod_400 = {3'b0, year_value[15:4]} * {12'd0, RECIP_25};

  assign div_4   = (year_value[1:0] == 2'd0);
  assign div_100 = div_4 && (({5'd0, quot_100} * 15'd25) == {1'b0, year_value[15:2]});
  assign div_400 = (year_value[3:0] == 4'd0)
                   && (({5'd0, quot_400} * 13'd25) == {1'b0, year_value[15:4]});
  assign leap    = div_400 || (div_4 && !div_100);

  assign doy_form = header_byte_next[3];
  assign doy      = {month_or_doy_high_next, day_or_doy_low_next};

  always_comb begin
    fmt_bad = (header_byte_next[2:0] == BAD_COUNT)
              || (hour_value_next > MAX_HOUR)
              || (minute_value_next > MAX_MIN_SEC)
              || (second_value_next > MAX_MIN_SEC)
              || subsecond_bad_next;
    if (doy_form) begin
      fmt_bad = fmt_bad || (doy > MAX_DOY);
    end else begin
      fmt_bad = fmt_bad || (month_or_doy_high_next > MAX_MONTH)
                || (day_or_doy_low_next > MAX_DAY);
    end
    doy_bad = doy_form && !leap && (doy == MAX_DOY);
    if (fmt_bad) begin
      status_next = ST_FORMAT;
    end else if (doy_bad) begin
      status_next = ST_DOY;
    end else begin
      status_next = ST_OK;
    end
  end

  // month is the number of month starts that the day of year lies past
  always_comb begin
    month_idx = 4'd0;
    for (int m = 1; m <= 11; m++) begin
      if (doy[DOY_W-1:0] > days_before(4'(m), leap)) begin
        month_idx = month_idx + 4'd1;
      end
    end
    if (month_idx > LAST_MONTH) month_idx = LAST_MONTH;
    doy_day = doy[DOY_W-1:0] - days_before(month_idx, leap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= 4'd0;
      skipping_rest <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (skipping_rest) begin
          if (end_of_buffer) begin
            skipping_rest <= 1'b0;
            byte_index    <= 4'd0;
          end
        end else if (done) begin
          byte_index    <= 4'd0;
          skipping_rest <= !end_of_buffer;
        end else if (end_of_buffer) begin
          byte_index <= 4'd0;
        end else begin
          byte_index <= byte_index + 4'd1;
        end
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !skipping_rest) begin
      header_byte          <= header_byte_next;
      month_or_doy_high    <= month_or_doy_high_next;
      day_or_doy_low       <= day_or_doy_low_next;
      hour_value           <= hour_value_next;
      minute_value         <= minute_value_next;
      second_value         <= second_value_next;
      hundredths_byte      <= hundredths_byte_next;
      ten_thousandths_byte <= ten_thousandths_byte_next;
      subsecond_bad        <= subsecond_bad_next;
      if (byte_index == 4'd1) year_value[15:8] <= data_byte;
      if (byte_index == 4'd2) year_value[7:0]  <= data_byte;
      if (byte_index == 4'd3) begin
        quot_100 <= prod_100[RECIP_SHIFT +: 10];
        quot_400 <= prod_400[RECIP_SHIFT +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_length <= total;
      year        <= 16'd0;
      month       <= 4'd0;
      day         <= 5'd0;
      hour        <= 5'd0;
      minute      <= 6'd0;
      second      <= 6'd0;
      microsecond <= 20'd0;
      if (cut_off) begin
        status <= ST_LENGTH;
      end else begin
        status <= status_next;
        if (status_next == ST_OK) begin
          year   <= year_value;
          hour   <= hour_value_next[4:0];
          minute <= minute_value_next[5:0];
          second <= second_value_next[5:0];
          microsecond <= {12'd0, hundredths_byte_next} * 20'd10000
                         + {12'd0, ten_thousandths_byte_next} * 20'd100;
          if (doy_form) begin
            month <= month_idx + 4'd1;
            day   <= doy_day[4:0];
          end else begin
            month <= month_or_doy_high_next[3:0];
            day   <= day_or_doy_low_next[4:0];
          end
        end
      end
    end
  end

endmodule

/* hw/rtl/ccstcd_chk.sv */
module ccstcd_chk (
  input logic        clk,
  input logic        rst,
  input logic        data_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  status,
  input logic [15:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic [19:0] microsecond,
  input logic [3:0]  code_length
);
  import ccstcd_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(year)
      && $stable(microsecond) && $stable(code_length))
    else $error("stalled result changed");

  // the data side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> result_valid)
    else $error("data stall without pending result");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> year == 16'd0 && month == 4'd0 && day == 5'd0
      && hour == 5'd0 && minute == 6'd0 && second == 6'd0 && microsecond == 20'd0)
    else $error("fields not zero on error status");

  a_ok_ranges: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_OK) |-> month <= 4'd12 && day <= 5'd31 && hour <= 5'd23
      && minute <= 6'd59 && second <= 6'd59 && microsecond <= 20'd999999
      && code_length != 4'd15)
    else $error("ok result out of range");

  a_length: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> code_length[3])
    else $error("code length below eight");

endmodule

bind ccs_time_code_decoder ccstcd_chk u_ccstcd_chk (.*);

/* bench/ccs_time_code_decoder_tb.sv */
module ccs_time_code_decoder_tb;
  import ccstcd_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RUN_LIMIT = 400000;
  localparam int TARGET_BYTES = 1800;
  localparam int CALM_BYTES = 1550;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    status_t     st;
    logic [15:0] yr;
    logic [3:0]  mon;
    logic [4:0]  dom;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
    logic [19:0] usec;
    logic [3:0]  len;
  } time_fields_t;

  class ccs_time_tracker;
    time_fields_t pending_times[$];
    int error_count = 0;
    logic [3:0]  byte_pos = '0;
    bit          skip_rest = 1'b0;
    logic [7:0]  hdr = '0;
    logic [15:0] yr = '0;
    logic [7:0]  mo_hi = '0;
    logic [7:0]  dy_lo = '0;
    logic [7:0]  hr = '0;
    logic [7:0]  mi = '0;
    logic [7:0]  se = '0;
    logic [7:0]  hund = '0;
    logic [7:0]  tenk = '0;
    bit          sub_bad = 1'b0;

    function bit leap_year(logic [15:0] y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function int unsigned month_days(int unsigned m, bit lp);
      case (m)
        1: return lp ? 29 : 28;
        3, 5, 8, 10: return 30;
        default: return 31;
      endcase
    endfunction

    function time_fields_t decode_code(int unsigned total);
      time_fields_t r;
      int unsigned n, doy, rest, m, usec;
      bit doy_form, lp;
      r = '0;
      r.st = ST_OK;
      r.len = total[3:0];
      n = hdr[2:0];
      doy_form = hdr[3];
      doy = {mo_hi, dy_lo};
      lp = leap_year(yr);
      // range checks come before the per-year day of year limit
      if (n == 7) r.st = ST_FORMAT;
      else if (doy_form && doy > 366) r.st = ST_FORMAT;
      else if (!doy_form && (mo_hi > 12 || dy_lo > 31)) r.st = ST_FORMAT;
      else if (hr > 23 || mi > 59 || se > 59 || sub_bad) r.st = ST_FORMAT;
      else if (doy_form && doy > (lp ? 366 : 365)) r.st = ST_DOY;
      if (r.st != ST_OK) return r;
      if (doy_form) begin
        m = 0;
        rest = doy;
        while (m < 11 && rest > month_days(m, lp)) begin
          rest -= month_days(m, lp);
          m++;
        end
        r.mon = 4'(m + 1);
        r.dom = 5'(rest);
      end else begin
        r.mon = mo_hi[3:0];
        r.dom = dy_lo[4:0];
      end
      usec = 0;
      if (n > 0) usec = hund * 10000;
      if (n > 1) usec += tenk * 100;
      r.yr = yr;
      r.hr = hr[4:0];
      r.mi = mi[5:0];
      r.se = se[5:0];
      r.usec = usec[19:0];
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      int unsigned idx, total;
      time_fields_t r;
      if (skip_rest) begin
        if (eob) begin
          skip_rest = 1'b0;
          byte_pos = '0;
        end
        return;
      end
      idx = byte_pos;
      case (idx)
        0: begin
          hdr = b;
          sub_bad = 1'b0;
          hund = '0;
          tenk = '0;
        end
        1: yr[15:8] = b;
        2: yr[7:0] = b;
        3: mo_hi = b;
        4: dy_lo = b;
        5: hr = b;
        6: mi = b;
        7: se = b;
        default: begin
          if (idx == 8) hund = b;
          if (idx == 9) tenk = b;
          if (b > 99) sub_bad = 1'b1;
        end
      endcase
      total = 8 + hdr[2:0];
      if (idx + 1 >= total) begin
        pending_times.push_back(decode_code(total));
        byte_pos = '0;
        skip_rest = !eob;
      end else if (eob) begin
        // cut-off code
        r = '0;
        r.st = ST_LENGTH;
        r.len = total[3:0];
        pending_times.push_back(r);
        byte_pos = '0;
      end else begin
        byte_pos = byte_pos + 4'd1;
      end
    endfunction

    task report(string msg);
      error_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(time_fields_t got);
      time_fields_t want;
      if (pending_times.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d", got.st));
        return;
      end
      want = pending_times.pop_front();
      cmp_field("status", got.st, want.st);
      cmp_field("year", got.yr, want.yr);
      cmp_field("month", got.mon, want.mon);
      cmp_field("day", got.dom, want.dom);
      cmp_field("hour", got.hr, want.hr);
      cmp_field("minute", got.mi, want.mi);
      cmp_field("second", got.se, want.se);
      cmp_field("microsecond", got.usec, want.usec);
      cmp_field("code_length", got.len, want.len);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = '0;
  logic        end_of_buffer = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [19:0] microsecond;
  logic [3:0]  code_length;

  ccs_time_tracker tracker;
  logic [7:0]   frame [15];
  time_fields_t seen;
  int           code_bytes = 0;
  int           code_count = 0;
  int           cycle_count = 0;
  int           tx_gap_pct = 10;
  int           rx_stall_pct = 10;
  bit           calm_tail = 1'b0;
  bit           hold_off_req = 1'b0;

  ccs_time_code_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .microsecond  (microsecond),
    .code_length  (code_length)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (!calm_tail && $urandom_range(0, 99) < tx_gap_pct) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    tracker.note_byte(b, eob);
  endtask

  function automatic void build_code(input logic [7:0] hdr, input logic [15:0] yr,
                                     input logic [7:0] f3, input logic [7:0] f4,
                                     input logic [7:0] hr, input logic [7:0] mi,
                                     input logic [7:0] se);
    int i;
    frame[0] = hdr;
    frame[1] = yr[15:8];
    frame[2] = yr[7:0];
    frame[3] = f3;
    frame[4] = f4;
    frame[5] = hr;
    frame[6] = mi;
    frame[7] = se;
    for (i = 8; i < 15; i++) frame[i] = 8'($urandom_range(0, 99));
  endfunction

  // cut_at above 0 and below the code length ends the buffer after that many bytes; trail adds skipped bytes
  task automatic send_frame(input int cut_at, input int trail);
    int total, last, i;
    total = 8 + frame[0][2:0];
    last = (cut_at > 0 && cut_at < total) ? cut_at : total;
    for (i = 0; i < last; i++)
      send_byte(frame[i], (i == last - 1) && (last < total || trail == 0));
    code_bytes += last;
    for (i = 0; i < trail; i++) send_byte(8'($urandom_range(0, 255)), i == trail - 1);
  endtask

  task automatic send_code(input logic [7:0] hdr, input logic [15:0] yr,
                           input logic [7:0] f3, input logic [7:0] f4,
                           input logic [7:0] hr, input logic [7:0] mi, input logic [7:0] se);
    build_code(hdr, yr, f3, f4, hr, mi, se);
    send_frame(0, 0);
  endtask

  function automatic logic [7:0] mostly_upto(input int unsigned top);
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, top));
  endfunction

  task automatic send_random_code();
    logic [7:0]  hdr;
    logic [15:0] yr, doy;
    int total, cut, trail, i;
    hdr = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) != 0) hdr[2:0] = 3'($urandom_range(0, 6));
    case ($urandom_range(0, 5))
      0: yr = 16'(100 * $urandom_range(0, 655));
      1: yr = 16'(4 * $urandom_range(0, 16383));
      default: yr = 16'($urandom_range(0, 65535));
    endcase
    if (hdr[3]) begin
      case ($urandom_range(0, 9))
        0: doy = 16'($urandom_range(0, 65535));
        1, 2: doy = 16'($urandom_range(365, 367));
        default: doy = 16'($urandom_range(0, 366));
      endcase
    end else begin
      doy = {mostly_upto(12), mostly_upto(31)};
    end
    build_code(hdr, yr, doy[15:8], doy[7:0], mostly_upto(23), mostly_upto(59),
               mostly_upto(59));
    for (i = 8; i < 15; i++)
      if ($urandom_range(0, 29) == 0) frame[i] = 8'($urandom_range(100, 255));
    // now and then pure noise
    if ($urandom_range(0, 24) == 0)
      for (i = 0; i < 15; i++) frame[i] = 8'($urandom_range(0, 255));
    total = 8 + frame[0][2:0];
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : 0;
    trail = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    send_frame(cut, trail);
  endtask

  task automatic run_directed();
    send_code(8'h00, 16'd2024, 8'd2, 8'd29, 8'd12, 8'd34, 8'd56);
    // zero month and day pass through
    send_code(8'h00, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    build_code(8'h02, 16'hFFFF, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59);
    frame[8] = 8'd99;
    frame[9] = 8'd99;
    send_frame(0, 0);
    send_code(8'h00, 16'd2023, 8'd13, 8'd1, 8'd0, 8'd0, 8'd0);
    send_code(8'h00, 16'd2023, 8'd1, 8'd32, 8'd0, 8'd0, 8'd0);
    send_code(8'h00, 16'd2023, 8'd1, 8'd1, 8'd24, 8'd0, 8'd0);
    send_code(8'h00, 16'd2023, 8'd1, 8'd1, 8'd0, 8'd60, 8'd0);
    send_code(8'h00, 16'd2023, 8'd1, 8'd1, 8'd0, 8'd0, 8'd60);
    // subsecond byte over 99, first and last positions
    build_code(8'h01, 16'd2023, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5);
    frame[8] = 8'd100;
    send_frame(0, 0);
    build_code(8'h06, 16'd2023, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5);
    frame[13] = 8'hFF;
    send_frame(0, 0);
    // subsecond count of seven is a format error with full length
    send_code(8'h07, 16'd2023, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5);
    // day of year form
    send_code(8'h08, 16'd2023, 8'h00, 8'h00, 8'd1, 8'd2, 8'd3);
    send_code(8'h08, 16'd2000, 8'h01, 8'h6E, 8'd1, 8'd2, 8'd3);
    send_code(8'h08, 16'd1900, 8'h01, 8'h6E, 8'd1, 8'd2, 8'd3);
    send_code(8'h09, 16'd2023, 8'h01, 8'h6D, 8'd1, 8'd2, 8'd3);
    send_code(8'h08, 16'd2023, 8'h01, 8'h6E, 8'd1, 8'd2, 8'd3);
    send_code(8'h08, 16'd2024, 8'h00, 8'd60, 8'd1, 8'd2, 8'd3);
    send_code(8'h0B, 16'd2023, 8'h00, 8'd60, 8'd1, 8'd2, 8'd3);
    send_code(8'h08, 16'd2024, 8'h01, 8'h6F, 8'd1, 8'd2, 8'd3);
    send_code(8'hFD, 16'd2024, 8'hFF, 8'hFF, 8'd1, 8'd2, 8'd3);
    // upper header bits are ignored
    send_code(8'hF0, 16'd1999, 8'd7, 8'd4, 8'd1, 8'd2, 8'd3);
    // buffer ends after the header alone, then one byte short
    build_code(8'h00, 16'd2023, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_frame(1, 0);
    build_code(8'h04, 16'd2023, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    send_frame(11, 0);
    // bytes after a complete code are dropped until the end flag
    build_code(8'h01, 16'd2023, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3);
    send_frame(0, 3);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen.st = status_t'(status);
      seen.yr = year;
      seen.mon = month;
      seen.dom = day;
      seen.hr = hour;
      seen.mi = minute;
      seen.se = second;
      seen.usec = microsecond;
      seen.len = code_length;
      tracker.check_result(seen);
    end
  end

  initial begin : result_side
    int hold_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // long hold so the output register fills and the byte side backs up
        hold_off_req = 1'b0;
        result_stall <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          hold_cycles++;
        end
      end else if (!calm_tail && $urandom_range(0, 99) < rx_stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat (calm_tail ? 1 : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    hold_off_req = 1'b1;
    tx_gap_pct = 0;
    repeat (15) send_random_code();
    while (code_bytes < TARGET_BYTES) begin
      if (code_count % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 5;
          2: tx_gap_pct = 20;
          default: tx_gap_pct = 50;
        endcase
        case ($urandom_range(0, 3))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 5;
          2: rx_stall_pct = 20;
          default: rx_stall_pct = 50;
        endcase
      end
      if (code_bytes >= CALM_BYTES) calm_tail = 1'b1;
      send_random_code();
      code_count++;
    end
    data_valid <= 1'b0;
    while (tracker.pending_times.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ccstcd_pkg.sv
hw/rtl/ccs_time_code_decoder.sv
hw/rtl/ccstcd_chk.sv
bench/ccs_time_code_decoder_tb.sv
